// ===== hdl/bounded_weight_mixed_radix_enumerator_core_macros.svh =====
// Assertion macros shared by the enumerator RTL.
`ifndef BOUNDED_WEIGHT_MIXED_RADIX_ENUMERATOR_CORE_MACROS_SVH
`define BOUNDED_WEIGHT_MIXED_RADIX_ENUMERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWMRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bwmre assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BWMRE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bwmre assertion failed");

`endif

// ===== hdl/bwmre_pkg.sv =====
// Types, codes and constants of the bounded-weight mixed-radix enumerator.
package bwmre_pkg;

  localparam int unsigned DIGITS_DEF     = 16;
  localparam int unsigned DIGIT_BITS_DEF = 4;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned CAP_W   = 8;
  localparam int unsigned SUM_O_W = 8;
  localparam int unsigned MASK_W  = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_ADVANCE = 2'd2
  } bwmre_cmd_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLEAR,
    DP_START,
    DP_FIND,
    DP_STEP,
    DP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_CARRY,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   ok;
  } dp_cmd_t;

  typedef struct packed {
    logic cap_hit;
    logic any_nz;
    logic low_last;
    logic below;
    logic pos_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/bwmre_in_if.sv =====
// Input word channel: command and limit load fields.
interface bwmre_in_if
  import bwmre_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] digit_index;
  logic [LIMIT_W-1:0] limit_value;

  modport source (output valid, output command, output digit_index, output limit_value,
                  input ready);
  modport sink   (input valid, input command, input digit_index, input limit_value,
                  output ready);
endinterface

// ===== hdl/bwmre_out_if.sv =====
// Output word channel: advance flag, sums and nonzero mask.
interface bwmre_out_if
  import bwmre_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               advanced_ok;
  logic [SUM_O_W-1:0] digit_sum;
  logic [SUM_O_W-1:0] log_multiplicity;
  logic [MASK_W-1:0]  nonzero_mask;

  modport source (output valid, output advanced_ok, output digit_sum,
                  output log_multiplicity, output nonzero_mask, input ready);
  modport sink   (input valid, input advanced_ok, input digit_sum,
                  input log_multiplicity, input nonzero_mask, output ready);
endinterface

// ===== hdl/bounded_weight_mixed_radix_enumerator_core.sv =====
// Load, clear and an unused command code: on accept the done state emits the result word.
// Advance: at the cap a find step first drops the lowest nonzero digit, then the carry
// ripples one digit a cycle through the datapath until a digit below its limit takes it.
// One word at a time; the next word is taken once the previous one is done.
// Reset (async, active low) zeroes digits, limits and sums; the cap resets to 1.
module bounded_weight_mixed_radix_enumerator_core
  import bwmre_pkg::*;
#(
  parameter int unsigned DIGITS     = DIGITS_DEF,
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  bwmre_in_if.sink         in_i,
  bwmre_out_if.source      out_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bwmre_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd)
  );

  bwmre_dp #(
    .DIGITS     (DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .digit_index_i      (in_i.digit_index),
    .limit_value_i      (in_i.limit_value),
    .cmd_i              (dp_cmd),
    .stat_o             (dp_stat),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .advanced_ok_o      (out_o.advanced_ok),
    .digit_sum_o        (out_o.digit_sum),
    .log_multiplicity_o (out_o.log_multiplicity),
    .nonzero_mask_o     (out_o.nonzero_mask)
  );

endmodule

// ===== hdl/bwmre_ctrl.sv =====
// Controller state machine of the enumerator.
`include "bounded_weight_mixed_radix_enumerator_core_macros.svh"

module bwmre_ctrl
  import bwmre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_command_i,
  output logic             in_ready_o,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        ok_q, ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ok_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

  // Next state and wrap flag.
  always_comb begin
    state_d = state_q;
    ok_d    = ok_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ok_d = 1'b1;
          case (bwmre_cmd_e'(in_command_i))
            CMD_ADVANCE: state_d = stat_i.cap_hit ? ST_FIND : ST_CARRY;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_FIND: begin
        // Cap reached: drop the lowest nonzero digit, carry into the next one; wrap if none or it is the top digit.
        if (!stat_i.any_nz || stat_i.low_last) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CARRY;
        end
      end
      ST_CARRY: begin
        if (stat_i.below) begin
          state_d = ST_DONE;
        end else if (stat_i.pos_last) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands and input handshake.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NONE;
    cmd_o.ok   = ok_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (bwmre_cmd_e'(in_command_i))
            CMD_LOAD:    cmd_o.op = DP_LOAD;
            CMD_CLEAR:   cmd_o.op = DP_CLEAR;
            CMD_ADVANCE: cmd_o.op = DP_START;
            default:     cmd_o.op = DP_NONE;
          endcase
        end
      end
      ST_FIND: begin
        if (stat_i.any_nz) begin
          cmd_o.op = DP_FIND;
        end
      end
      ST_CARRY: cmd_o.op = DP_STEP;
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = DP_EMIT;
        end
      end
      default: cmd_o.op = DP_NONE;
    endcase
  end

  `BWMRE_ASSERT_IMP(a_ready_only_idle, clk_i, rst_ni, state_q != ST_IDLE, !in_ready_o)
  `BWMRE_ASSERT_NXT(a_find_one_cycle, clk_i, rst_ni, state_q == ST_FIND, state_q != ST_FIND)
  `BWMRE_ASSERT_NXT(a_done_to_idle, clk_i, rst_ni,
                    state_q == ST_DONE && stat_i.out_free, state_q == ST_IDLE)

endmodule

// ===== hdl/bwmre_dp.sv =====
// Datapath of the enumerator: digits, limits, sums, cap and result register.
`include "bounded_weight_mixed_radix_enumerator_core_macros.svh"

module bwmre_dp
  import bwmre_pkg::*;
#(
  parameter int unsigned DIGITS     = DIGITS_DEF,
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  input  logic [INDEX_W-1:0] digit_index_i,
  input  logic [LIMIT_W-1:0] limit_value_i,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               advanced_ok_o,
  output logic [SUM_O_W-1:0] digit_sum_o,
  output logic [SUM_O_W-1:0] log_multiplicity_o,
  output logic [MASK_W-1:0]  nonzero_mask_o
);

  localparam int unsigned PW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned SUM_W  = $clog2(DIGITS * ((1 << DIGIT_BITS) - 1) + 1);
  localparam int unsigned CMP_W  = (SUM_W > CAP_W) ? SUM_W : CAP_W;
  localparam logic [PW-1:0]    LastPos = PW'(DIGITS - 1);
  localparam logic [SUM_W-1:0] SumOne  = SUM_W'(1);
  localparam logic [CMP_W-1:0] SatMax  = CMP_W'((1 << SUM_O_W) - 1);

  logic [DIGIT_BITS-1:0] digits_q [DIGITS];
  logic [DIGIT_BITS-1:0] digits_d [DIGITS];
  logic [DIGIT_BITS-1:0] limits_q [DIGITS];
  logic [DIGIT_BITS-1:0] limits_d [DIGITS];
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [SUM_W-1:0]      lm_q, lm_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [CAP_W-1:0]      cap_q;
  logic                  out_valid_q, out_valid_d;

  logic [DIGITS-1:0]     nz;
  logic [PW-1:0]         low_idx;
  logic [DIGIT_BITS-1:0] low_v;
  logic [DIGIT_BITS-1:0] cur_v;
  logic [DIGIT_BITS-1:0] cur_l;
  logic                  load_hit;
  logic [MASK_W-1:0]     mask;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      nz[i] = (digits_q[i] != '0);
    end
  end

  // Lowest nonzero position: scan down so the lowest set flag wins.
  always_comb begin
    low_idx = '0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (nz[i]) begin
        low_idx = PW'(i);
      end
    end
  end

  assign low_v    = digits_q[low_idx];
  assign cur_v    = digits_q[pos_q];
  assign cur_l    = limits_q[pos_q];
  assign load_hit = (32'(digit_index_i) < DIGITS);

  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < DIGITS) begin : g_on
      assign mask[g] = nz[g];
    end else begin : g_off
      assign mask[g] = 1'b0;
    end
  end

  always_comb begin
    stat_o.cap_hit  = (CMP_W'(sum_q) >= CMP_W'(cap_q));
    stat_o.any_nz   = (nz != '0);
    stat_o.low_last = (low_idx == LastPos);
    stat_o.below    = (cur_v < cur_l);
    stat_o.pos_last = (pos_q == LastPos);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    digits_d    = digits_q;
    limits_d    = limits_q;
    sum_d       = sum_q;
    lm_d        = lm_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      DP_LOAD: begin
        if (load_hit) begin
          limits_d[PW'(digit_index_i)] = DIGIT_BITS'(limit_value_i);
        end
      end
      DP_CLEAR: begin
        for (int i = 0; i < DIGITS; i++) begin
          digits_d[i] = '0;
        end
        sum_d = '0;
        lm_d  = '0;
      end
      DP_START: pos_d = '0;
      DP_FIND: begin
        digits_d[low_idx] = '0;
        sum_d = sum_q - SUM_W'(low_v);
        if (low_v > DIGIT_BITS'(1)) begin
          lm_d = lm_q - (SUM_W'(low_v) - SumOne);
        end
        pos_d = low_idx + PW'(1);
      end
      DP_STEP: begin
        if (cur_v < cur_l) begin
          // Digit below its limit: increment and stop the carry.
          digits_d[pos_q] = cur_v + DIGIT_BITS'(1);
          sum_d = sum_q + SumOne;
          if (cur_v != '0) begin
            lm_d = lm_q + SumOne;
          end
        end else begin
          // At or above its limit: clear and pass the carry up.
          digits_d[pos_q] = '0;
          sum_d = sum_q - SUM_W'(cur_v);
          if (cur_v > DIGIT_BITS'(1)) begin
            lm_d = lm_q - (SUM_W'(cur_v) - SumOne);
          end
          pos_d = pos_q + PW'(1);
        end
      end
      DP_EMIT: out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        digits_q[i] <= '0;
        limits_q[i] <= '0;
      end
      sum_q       <= '0;
      lm_q        <= '0;
      pos_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      digits_q    <= digits_d;
      limits_q    <= limits_d;
      sum_q       <= sum_d;
      lm_q        <= lm_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Result word: saturate both sums to the output width.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_EMIT) begin
      advanced_ok_o      <= cmd_i.ok;
      digit_sum_o        <= (CMP_W'(sum_q) > SatMax) ? '1 : SUM_O_W'(sum_q);
      log_multiplicity_o <= (CMP_W'(lm_q) > SatMax) ? '1 : SUM_O_W'(lm_q);
      nonzero_mask_o     <= mask;
    end
  end

  assign out_valid_o = out_valid_q;

  `BWMRE_ASSERT_IMP(a_sum_zero_iff_no_digits, clk_i, rst_ni, 1'b1,
                    (sum_q == '0) == (nz == '0))
  `BWMRE_ASSERT_IMP(a_lm_within_sum, clk_i, rst_ni, 1'b1, lm_q <= sum_q)
  `BWMRE_ASSERT_NXT(a_clear_zeroes_sums, clk_i, rst_ni, cmd_i.op == DP_CLEAR,
                    sum_q == '0 && lm_q == '0)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the enumerator core: directed and random command words vs a predictor.
module tb_top;
  import bwmre_pkg::*;

  localparam int unsigned NDIG = DIGITS_DEF;
  localparam int unsigned SETTLE_CYCLES = NDIG + 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_WORDS = 170;
  localparam int unsigned HOLD_AFTER = 500;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
    logic [LIMIT_W-1:0] lim;
  } cmd_word_t;

  typedef struct packed {
    logic               ok;
    logic [SUM_O_W-1:0] sum;
    logic [SUM_O_W-1:0] lmul;
    logic [MASK_W-1:0]  mask;
  } result_word_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  bwmre_in_if  cmd_if ();
  bwmre_out_if res_if ();

  bounded_weight_mixed_radix_enumerator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cmd_if),
    .out_o       (res_if)
  );

  // Predictor state
  logic [DIGIT_BITS_DEF-1:0] digit_q [NDIG] = '{default: '0};
  logic [DIGIT_BITS_DEF-1:0] limit_q [NDIG] = '{default: '0};
  int unsigned               digit_total = 0;
  logic [CAP_W-1:0]          cap_q = CAP_RESET;

  cmd_word_t    cmd_backlog[$];
  result_word_t predicted_results[$];

  int unsigned error_count = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned cycle_count = 0;
  logic        cmd_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned calm_left = 0;
  logic        long_hold = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One carry pass; returns 0 on wrap.
  function automatic logic advance_digits();
    int unsigned first;
    int unsigned p;
    logic        carry;
    first = 0;
    carry = 1'b1;
    if (digit_total >= cap_q) begin
      p = 0;
      while (p < NDIG && digit_q[p] == 0) p++;
      if (p >= NDIG) return 1'b0;
      digit_total -= digit_q[p];
      digit_q[p] = '0;
      first = p + 1;
    end
    for (p = first; p < NDIG && carry; p++) begin
      if (digit_q[p] < limit_q[p]) begin
        digit_q[p] = digit_q[p] + 1'b1;
        digit_total += 1;
        carry = 1'b0;
      end else begin
        digit_total -= digit_q[p];
        digit_q[p] = '0;
      end
    end
    return !carry;
  endfunction

  function automatic result_word_t step_enumerator(input cmd_word_t w);
    result_word_t res;
    int unsigned  lm;
    res = '0;
    res.ok = 1'b1;
    lm = 0;
    if (w.cmd == CMD_LOAD) begin
      limit_q[w.idx] = w.lim;
    end else if (w.cmd == CMD_CLEAR) begin
      foreach (digit_q[i]) digit_q[i] = '0;
      digit_total = 0;
    end else if (w.cmd == CMD_ADVANCE) begin
      res.ok = advance_digits();
    end
    for (int i = 0; i < NDIG; i++) begin
      if (digit_q[i] > 1) lm += digit_q[i] - 1;
      if (digit_q[i] != 0 && i < MASK_W) res.mask[i] = 1'b1;
    end
    res.sum  = (digit_total > 255) ? 8'd255 : digit_total[SUM_O_W-1:0];
    res.lmul = (lm > 255) ? 8'd255 : lm[SUM_O_W-1:0];
    return res;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Prediction on input accept, compare on output accept
  always @(posedge clk_i) begin : check_words
    result_word_t want;
    cmd_taken <= cmd_if.valid && cmd_if.ready;
    if (rst_ni) begin
      if (cfg_we_i) cap_q = cfg_wdata_i;
      if (cmd_if.valid && cmd_if.ready) begin
        words_in++;
        predicted_results.push_back(step_enumerator(
          '{cmd: cmd_if.command, idx: cmd_if.digit_index, lim: cmd_if.limit_value}));
      end
      if (res_if.valid && res_if.ready) begin
        words_out++;
        if (predicted_results.size() == 0) begin
          flag_error($sformatf("result word %0d with nothing expected", words_out));
        end else begin
          want = predicted_results.pop_front();
          if (res_if.advanced_ok !== want.ok)
            flag_error($sformatf("word %0d advanced_ok got %0b want %0b",
                                 words_out, res_if.advanced_ok, want.ok));
          if (res_if.digit_sum !== want.sum)
            flag_error($sformatf("word %0d digit_sum got %0d want %0d",
                                 words_out, res_if.digit_sum, want.sum));
          if (res_if.log_multiplicity !== want.lmul)
            flag_error($sformatf("word %0d log_multiplicity got %0d want %0d",
                                 words_out, res_if.log_multiplicity, want.lmul));
          if (res_if.nonzero_mask !== want.mask)
            flag_error($sformatf("word %0d nonzero_mask got %h want %h",
                                 words_out, res_if.nonzero_mask, want.mask));
        end
      end
    end
  end

  // Quiet spells: no gaps on either side
  always @(negedge clk_i) begin
    if (calm_left != 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(50, 150);
  end

  // Command word driver
  always @(negedge clk_i) begin : drive_cmds
    cmd_word_t w;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (cmd_if.valid && !cmd_taken) begin
      // hold the offered word
    end else if (send_gap != 0) begin
      cmd_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (cmd_backlog.size() != 0) begin
      w = cmd_backlog.pop_front();
      cmd_if.valid       <= 1'b1;
      cmd_if.command     <= w.cmd;
      cmd_if.digit_index <= w.idx;
      cmd_if.limit_value <= w.lim;
      send_gap <= (calm_left != 0) ? 0 : pick_gap();
    end else begin
      cmd_if.valid <= 1'b0;
    end
  end

  // One long receiver hold-off, counted here, while the sender keeps offering
  always @(negedge clk_i) begin
    if (!hold_used && words_in >= HOLD_AFTER) begin
      long_hold <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (long_hold) begin
      if (hold_left == 0) long_hold <= 1'b0;
      else hold_left <= hold_left - 1;
    end
  end

  // Result ready with random stalls
  always @(negedge clk_i) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (recv_gap != 0) begin
      rdy = 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (calm_left == 0 && $urandom_range(0, 3) == 0) begin
      recv_gap <= pick_gap();
    end
    res_if.ready <= rdy && !long_hold;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** bounded_weight_mixed_radix_enumerator_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int unsigned idx,
                           input int unsigned lim);
    cmd_backlog.push_back('{cmd: cmd, idx: idx[INDEX_W-1:0], lim: lim[LIMIT_W-1:0]});
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (cmd_backlog.size() != 0 || cmd_if.valid || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cap(input int unsigned v);
    cfg_wdata_i <= v[CAP_W-1:0];
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Limits first, then mostly advances with some reloads, clears and noise
  task automatic random_phase(input int unsigned lim_hi);
    int unsigned r;
    for (int i = 0; i < NDIG; i++) queue_cmd(CMD_LOAD, i, $urandom_range(0, lim_hi));
    for (int n = 0; n < PHASE_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 72)
        queue_cmd(CMD_ADVANCE, $urandom_range(0, 15), $urandom_range(0, 15));
      else if (r < 80)
        queue_cmd(CMD_LOAD, $urandom_range(0, NDIG - 1), $urandom_range(0, lim_hi));
      else if (r < 86)
        queue_cmd(CMD_LOAD, $urandom_range(0, NDIG - 1), $urandom_range(0, 15));
      else if (r < 93)
        queue_cmd(CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
      else
        queue_cmd(CMD_NOP, $urandom_range(0, 15), $urandom_range(0, 15));
    end
  endtask

  initial begin : stimulus
    int unsigned caps [8] = '{240, 0, 5, 1, 240, 12, 2, 100};
    int unsigned lims [8] = '{15, 3, 2, 1, 3, 15, 1, 7};
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = '0;
    cmd_if.digit_index = '0;
    cmd_if.limit_value = '0;
    res_if.ready       = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Cap 1 from reset: wrap on zero limits, single-digit walk, top-digit wrap
    queue_cmd(CMD_ADVANCE, 0, 0);
    queue_cmd(CMD_LOAD, 0, 15);
    queue_cmd(CMD_LOAD, 15, 15);
    queue_cmd(CMD_LOAD, 5, 3);
    repeat (4) queue_cmd(CMD_ADVANCE, 15, 15);
    queue_cmd(CMD_NOP, 9, 6);
    wait_quiet();

    // Cap reached with all digits zero
    write_cap(0);
    queue_cmd(CMD_ADVANCE, 0, 0);
    wait_quiet();

    // Climb digit 0, then lower its limit below the digit
    write_cap(240);
    repeat (6) queue_cmd(CMD_ADVANCE, 3, 12);
    queue_cmd(CMD_LOAD, 0, 2);
    queue_cmd(CMD_LOAD, 1, 1);
    repeat (3) queue_cmd(CMD_ADVANCE, 0, 0);
    wait_quiet();

    // Sum above a lowered cap
    write_cap(2);
    queue_cmd(CMD_ADVANCE, 10, 5);
    queue_cmd(CMD_CLEAR, 6, 9);
    queue_cmd(CMD_LOAD, 7, 10);
    wait_quiet();

    foreach (caps[p]) begin
      write_cap(caps[p]);
      random_phase(lims[p]);
      wait_quiet();
    end
    write_cap($urandom_range(0, 240));
    random_phase(4);
    wait_quiet();

    if (error_count == 0) begin
      $display("** bounded_weight_mixed_radix_enumerator_core: PASSED **");
    end else begin
      $display("** bounded_weight_mixed_radix_enumerator_core: FAILED **");
    end
    $finish;
  end

endmodule
